>>> src/psu_pkg.sv
// Shared types, constants and helper functions for the PNG scanline unfilter.
package psu_pkg;

  // Default size of the previous-row line buffer, in bytes.
  localparam int DEFAULT_MAX_ROW_BYTES = 8192;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_COLOR_KIND   = 2'd1,
    CFG_SAMPLE_DEPTH = 2'd2,
    CFG_IMAGE_WIDTH  = 2'd3
  } cfg_idx_t;

  // Filter mode codes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_UP   = 2'd2;

  // Color type codes.
  localparam logic [2:0] COLOR_GRAY       = 3'd0;
  localparam logic [2:0] COLOR_RGB        = 3'd2;
  localparam logic [2:0] COLOR_GRAY_ALPHA = 3'd4;
  localparam logic [2:0] COLOR_RGBA       = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [1:0]  RST_FILTER_MODE  = MODE_NONE;
  localparam logic [2:0]  RST_COLOR_KIND   = COLOR_RGB;
  localparam logic [4:0]  RST_SAMPLE_DEPTH = 5'd8;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;

  // Sample depth limits.
  localparam logic [4:0] DEPTH_MIN = 5'd1;
  localparam logic [4:0] DEPTH_MAX = 5'd16;

  // Configuration register file.
  typedef struct packed {
    logic [1:0]  filter_mode;
    logic [2:0]  color_kind;
    logic [4:0]  sample_depth;
    logic [10:0] image_width;
  } cfg_t;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] raw_byte;
    logic       image_start;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_last;
    logic       bad_format;
  } out_t;

  // Per-byte control decided by the row tracker.
  typedef struct packed {
    logic       first_row;
    logic       row_last;
    logic       bad_format;
    logic       use_sub;
    logic       use_up;
    logic [2:0] bpp_m1;
  } item_ctrl_t;

  // Channels per color type; zero marks an invalid type.
  function automatic logic [2:0] channel_count(input logic [2:0] kind);
    logic [2:0] ch;
    case (kind)
      COLOR_GRAY:       ch = 3'd1;
      COLOR_RGB:        ch = 3'd3;
      COLOR_GRAY_ALPHA: ch = 3'd2;
      COLOR_RGBA:       ch = 3'd4;
      default:          ch = 3'd0;
    endcase
    return ch;
  endfunction

endpackage

>>> src/psu_row_track.sv
// Row geometry and byte position tracking for each incoming byte.
module psu_row_track #(
  parameter int MAX_ROW_BYTES = psu_pkg::DEFAULT_MAX_ROW_BYTES,
  parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  psu_pkg::cfg_t           cfg,
  input  logic                    accept,
  input  logic                    image_start,
  output logic [AW-1:0]           pos,
  output psu_pkg::item_ctrl_t     ctrl
);
  import psu_pkg::*;

  localparam int PW = 15;
  localparam int LW = (AW + 1 > PW) ? AW + 1 : PW;

  logic [AW-1:0] column_pos_r, column_pos_nxt;
  logic          first_row_r, first_row_nxt;

  logic [4:0]    depth_c;
  logic [2:0]    ch;
  logic          bad;
  logic [6:0]    bits_per_px;
  logic [6:0]    bits_round;
  logic [3:0]    bpp;
  logic [10:0]   width_c;
  logic [PW-1:0] row_prod;
  logic [LW-1:0] row_len;
  logic [LW-1:0] pos_inc;
  logic          first_row;
  logic          last;

  // Bytes per pixel and row length from the configuration.
  always_comb begin
    ch  = channel_count(cfg.color_kind);
    bad = (ch == 3'd0);
    if (cfg.sample_depth < DEPTH_MIN) begin
      depth_c = DEPTH_MIN;
    end else if (cfg.sample_depth > DEPTH_MAX) begin
      depth_c = DEPTH_MAX;
    end else begin
      depth_c = cfg.sample_depth;
    end
    bits_per_px = {2'b00, depth_c} * {4'b0000, ch};
    bits_round  = bits_per_px + 7'd7;
    bpp         = bad ? 4'd1 : bits_round[6:3];
    width_c     = (cfg.image_width == 11'd0) ? 11'd1 : cfg.image_width;
    row_prod    = {4'b0000, width_c} * {11'b0, bpp};
    if (LW'(row_prod) > LW'(MAX_ROW_BYTES)) begin
      row_len = LW'(MAX_ROW_BYTES);
    end else begin
      row_len = LW'(row_prod);
    end
  end

  // Position of this byte and the end-of-row decision.
  always_comb begin
    pos       = image_start ? '0 : column_pos_r;
    first_row = image_start ? 1'b1 : first_row_r;
    pos_inc   = LW'(pos) + LW'(1);
    last      = (pos_inc >= row_len);

    ctrl.first_row  = first_row;
    ctrl.row_last   = last;
    ctrl.bad_format = bad;
    ctrl.use_sub    = !bad && (cfg.filter_mode == MODE_SUB);
    ctrl.use_up     = !bad && (cfg.filter_mode == MODE_UP);
    ctrl.bpp_m1     = 3'(bpp - 4'd1);

    column_pos_nxt = column_pos_r;
    first_row_nxt  = first_row_r;
    if (accept) begin
      column_pos_nxt = last ? '0 : pos_inc[AW-1:0];
      first_row_nxt  = last ? 1'b0 : first_row;
    end
  end

  // Row position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= '0;
      first_row_r  <= 1'b1;
    end else begin
      column_pos_r <= column_pos_nxt;
      first_row_r  <= first_row_nxt;
    end
  end

endmodule

>>> src/psu_line_buf.sv
// Previous-row line buffer with registered read and write-through forwarding.
module psu_line_buf #(
  parameter int MAX_ROW_BYTES = psu_pkg::DEFAULT_MAX_ROW_BYTES,
  parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);
  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a write to the same address in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/psu_recon.sv
// Reconstruction stage: add of the left or up neighbor and the result register.
module psu_recon #(
  parameter int MAX_ROW_BYTES = psu_pkg::DEFAULT_MAX_ROW_BYTES,
  parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  psu_pkg::in_t        in_item,
  input  logic [AW-1:0]       in_pos,
  input  psu_pkg::item_ctrl_t in_ctrl,
  output logic                stage_ready,
  input  logic [7:0]          up_byte,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psu_pkg::out_t       out_item
);
  import psu_pkg::*;

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_raw_r;
  logic          s1_start_r;
  logic [AW-1:0] s1_pos_r;
  item_ctrl_t    s1_ctrl_r;

  logic [63:0]   hist_r, hist_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r;

  logic          advance;
  logic [63:0]   hist_base;
  logic [7:0]    left_byte;
  logic [7:0]    up_val;
  logic [7:0]    result;

  // Stage handshake: the held byte moves on when the result register frees up.
  assign advance     = s1_valid_r && (!out_valid_r || out_ready);
  assign stage_ready = !s1_valid_r || advance;

  // Reconstructed byte for the held transaction.
  always_comb begin
    hist_base = s1_start_r ? 64'd0 : hist_r;
    left_byte = hist_base[{s1_ctrl_r.bpp_m1, 3'b000} +: 8];
    up_val    = s1_ctrl_r.first_row ? 8'd0 : up_byte;
    if (s1_ctrl_r.use_sub) begin
      result = s1_raw_r + left_byte;
    end else if (s1_ctrl_r.use_up) begin
      result = s1_raw_r + up_val;
    end else begin
      result = s1_raw_r;
    end
  end

  // Next-state logic for the stage, history and result valid.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    hist_nxt = hist_r;
    if (advance) begin
      hist_nxt = s1_ctrl_r.row_last ? 64'd0 : {hist_base[55:0], result};
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      hist_r      <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_raw_r   <= in_item.raw_byte;
      s1_start_r <= in_item.image_start;
      s1_pos_r   <= in_pos;
      s1_ctrl_r  <= in_ctrl;
    end
    if (advance) begin
      out_r.pixel_byte <= result;
      out_r.row_last   <= s1_ctrl_r.row_last;
      out_r.bad_format <= s1_ctrl_r.bad_format;
    end
  end

  // Every result is also the previous-row byte for the next row.
  assign wr_en     = advance;
  assign wr_addr   = s1_pos_r;
  assign wr_data   = result;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> src/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: config registers and pipeline wiring.
// Pipeline: an accepted byte loads the input stage and the line buffer read register,
// then the result register once that is free. Throughput: one byte per cycle while the
// output is not stalled, one line buffer read and one write per cycle. Reset:
// synchronous active-low reset clears the pipeline, row position and history and loads
// the configuration defaults; no line buffer clear.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = psu_pkg::DEFAULT_MAX_ROW_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  psu_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psu_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psu_pkg::*;

  localparam int AW = $clog2(MAX_ROW_BYTES);

  cfg_t          cfg_r, cfg_nxt;
  logic          accept;
  logic [AW-1:0] pos;
  item_ctrl_t    ctrl;
  logic [7:0]    up_byte;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILTER_MODE:  cfg_nxt.filter_mode  = cfg_data[1:0];
        CFG_COLOR_KIND:   cfg_nxt.color_kind   = cfg_data[2:0];
        CFG_SAMPLE_DEPTH: cfg_nxt.sample_depth = cfg_data[4:0];
        CFG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_data[10:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode  <= RST_FILTER_MODE;
      cfg_r.color_kind   <= RST_COLOR_KIND;
      cfg_r.sample_depth <= RST_SAMPLE_DEPTH;
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input transaction acceptance.
  assign accept = in_valid && in_ready;

  psu_row_track #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .AW           (AW)
  ) u_row_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .image_start(in_data.image_start),
    .pos        (pos),
    .ctrl       (ctrl)
  );

  psu_line_buf #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .AW           (AW)
  ) u_line_buf (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(pos),
    .rd_data(up_byte),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  psu_recon #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .AW           (AW)
  ) u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_data),
    .in_pos     (pos),
    .in_ctrl    (ctrl),
    .stage_ready(in_ready),
    .up_byte    (up_byte),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_data)
  );

endmodule
